// ===== rtl/core/sks_pkg.sv =====
package sks_pkg;

   // operation codes carried in req.kind; code 3 behaves as a lookup
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   // result codes carried in rsp.status
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam int unsigned IN_KEY_WIDTH   = 32;
   localparam int unsigned POSITION_WIDTH = 6;
   localparam int unsigned COUNT_WIDTH    = 7;

   typedef enum logic {
      ST_IDLE,
      ST_UPD
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic rem_en;
   } ctl_type;

   // compare results of one cell against the key of the current item
   typedef struct packed {
      logic lt;
      logic le;
   } flag_type;

endpackage

// ===== rtl/core/sks_req_if.sv =====
interface sks_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           kind;
   logic [sks_pkg::IN_KEY_WIDTH-1:0]     key;

   modport source (output valid, output kind, output key, input ready);
   modport sink   (input valid, input kind, input key, output ready);
endinterface

// ===== rtl/core/sks_rsp_if.sv =====
interface sks_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic                                 found;
   logic [sks_pkg::POSITION_WIDTH-1:0]   position;
   logic [sks_pkg::COUNT_WIDTH-1:0]      count_after;

   modport source (output valid, output status, output found, output position,
                   output count_after, input ready);
   modport sink   (input valid, input status, input found, input position,
                   input count_after, output ready);
endinterface

// ===== rtl/core/sks_cell.sv =====
module sks_cell #(
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic                   clock,
   input  sks_pkg::ctl_type       ctl,
   input  logic                   valid,
   input  logic [KEY_WIDTH-1:0]   cmp_key,
   input  logic [KEY_WIDTH-1:0]   ins_key,
   input  logic [KEY_WIDTH-1:0]   left_key,
   input  sks_pkg::flag_type      left_flags,
   input  logic [KEY_WIDTH-1:0]   right_key,
   output logic [KEY_WIDTH-1:0]   key,
   output sks_pkg::flag_type      flags
);
   import sks_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   flag_type             flags_ff, flags_in;

   always_comb begin
      key_in   = key_ff;
      flags_in = flags_ff;
      if (ctl.cmp_en) begin
         flags_in.lt = valid && (key_ff < cmp_key);
         flags_in.le = valid && (key_ff <= cmp_key);
      end
      // insert: cells past the slot take the left key, the slot takes the new key
      if (ctl.ins_en && !flags_ff.le) begin
         key_in = left_flags.le ? ins_key : left_key;
      end
      // remove: cells from the first match on take the right key
      if (ctl.rem_en && !flags_ff.lt) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      flags_ff <= flags_in;
   end

   assign key   = key_ff;
   assign flags = flags_ff;

endmodule

// ===== rtl/core/sks_enc.sv =====
module sks_enc #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned IW    = 6
) (
   input  logic [DEPTH-1:0] onehot,
   output logic [IW-1:0]    index
);

   always_comb begin
      index = '0;
      for (int unsigned i = 0; i < DEPTH; i++) begin
         if (onehot[i]) begin
            index = index | IW'(i);
         end
      end
   end

endmodule

// ===== rtl/core/sorted_key_set_core.sv =====
// Channel  Dir  Handshake       Payload
// req      in   valid/ready     kind[1:0], key[31:0]
// rsp      out  valid/ready     status[1:0], found, position[5:0], count_after[6:0]
//
// The accept edge registers every cell's compare against the key; the update
// edge, once the result register is free, shifts the row of cells and loads
// the result register. No new item is taken until that update is done.
// Reset (synchronous) empties the set; cell contents are left as they are.
// A new item is taken while an earlier result waits on rsp; the update edge
// holds until the result register is free.
module sorted_key_set_core #(
   parameter int unsigned DEPTH     = 64,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sks_req_if.sink    req,
   sks_rsp_if.source  rsp
);
   import sks_pkg::*;

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = (IW > POSITION_WIDTH) ? IW : POSITION_WIDTH;
   localparam int unsigned OW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [1:0]              kind_ff, kind_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              status_ff, status_in;
   logic                    found_ff, found_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [COUNT_WIDTH-1:0]  count_after_ff, count_after_in;

   logic                    accept;
   logic                    upd_done;
   logic                    full;
   logic                    present;
   ctl_type                 ctl;
   logic [KEY_WIDTH-1:0]    cmp_key;

   logic [KEY_WIDTH-1:0]    cell_key [DEPTH];
   flag_type                cell_flags [DEPTH];
   logic [DEPTH-1:0]        cell_valid;
   logic [DEPTH-1:0]        eq_v;
   logic [DEPTH-1:0]        lb_hot;   // first cell not less than the key
   logic [DEPTH-1:0]        ub_hot;   // first cell greater than the key
   logic [IW-1:0]           lb_idx, ub_idx;
   logic [PW-1:0]           pos_ext;
   logic [OW-1:0]           cnt_ext;

   assign accept   = req.valid && req.ready;
   assign upd_done = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp.ready);
   assign full     = (count_ff == CW'(DEPTH));
   assign cmp_key  = KEY_WIDTH'(req.key);

   // ---------------- row of cells ----------------
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [KEY_WIDTH-1:0] left_key, right_key;
         flag_type             left_flags;

         if (gi == 0) begin : g_first
            assign left_key   = key_ff;
            assign left_flags = '{lt: 1'b1, le: 1'b1};
         end else begin : g_mid
            assign left_key   = cell_key[gi-1];
            assign left_flags = cell_flags[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_key = cell_key[gi];
         end else begin : g_inner
            assign right_key = cell_key[gi+1];
         end

         assign cell_valid[gi] = (count_ff > CW'(gi));
         // sorted order makes lt and le thermometer codes, so each has one edge
         assign eq_v[gi]   = cell_flags[gi].le && !cell_flags[gi].lt;
         assign lb_hot[gi] = !cell_flags[gi].lt && left_flags.lt;
         assign ub_hot[gi] = !cell_flags[gi].le && left_flags.le;

         sks_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .valid      (cell_valid[gi]),
            .cmp_key    (cmp_key),
            .ins_key    (key_ff),
            .left_key   (left_key),
            .left_flags (left_flags),
            .right_key  (right_key),
            .key        (cell_key[gi]),
            .flags      (cell_flags[gi])
         );
      end
   endgenerate

   sks_enc #(.DEPTH(DEPTH), .IW(IW)) u_enc_lb (.onehot(lb_hot), .index(lb_idx));
   sks_enc #(.DEPTH(DEPTH), .IW(IW)) u_enc_ub (.onehot(ub_hot), .index(ub_idx));

   // the first cell not less than the key holds it: key present
   assign present = |(lb_hot & eq_v);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
      position_ff    <= position_in;
      count_after_ff <= count_after_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      ctl            = '0;
      req.ready      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      status_in      = status_ff;
      found_in       = found_ff;
      position_in    = position_ff;
      count_after_in = count_after_ff;
      pos_ext        = '0;
      cnt_ext        = '0;

      case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is held
            req.ready = !reset;
            if (req.valid && !reset) begin
               ctl.cmp_en = 1'b1;
               kind_in    = req.kind;
               key_in     = cmp_key;
               state_in   = ST_UPD;
            end
         end
         ST_UPD: begin
            if (upd_done) begin
               status_in = STATUS_OK;
               case (kind_ff)
                  KIND_INSERT: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctl.ins_en = 1'b1;
                        pos_ext    = PW'(ub_idx);
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  KIND_REMOVE: begin
                     if (present) begin
                        ctl.rem_en = 1'b1;
                        pos_ext    = PW'(lb_idx);
                        count_in   = count_ff - CW'(1);
                     end else begin
                        status_in = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (present) begin
                        pos_ext = PW'(lb_idx);
                     end else begin
                        status_in = STATUS_NOT_FOUND;
                     end
                  end
               endcase
               cnt_ext        = OW'(count_in);
               found_in       = present;
               position_in    = pos_ext[POSITION_WIDTH-1:0];
               count_after_in = cnt_ext[COUNT_WIDTH-1:0];
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.found       = found_ff;
   assign rsp.position    = position_ff;
   assign rsp.count_after = count_after_ff;

   // ---------------- checks ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_accept_to_upd: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPD))
      else $error("accepted item did not reach update");

   a_upd_result: assert property (@(posedge clock) disable iff (reset)
      upd_done |=> rsp_valid_ff)
      else $error("update finished without a result");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (upd_done && (kind_ff == KIND_INSERT) && !full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the set");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (status_ff != STATUS_NOT_FOUND))
      else $error("present key reported as not found");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import sks_pkg::*;

   localparam int unsigned SET_DEPTH   = 64;
   localparam int unsigned RANDOM_OPS  = 1700;
   localparam int unsigned POOL_SIZE   = 20;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned TAIL_CYCLES = 10;

   // spare opcode, not named in the package; the block treats it as a lookup
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct {
      logic [1:0]            kind;
      logic [IN_KEY_WIDTH-1:0] key;
      bit                    wait_idle;   // hold this item until all results are back
   } set_op_type;

   typedef struct packed {
      logic [1:0]                status;
      logic                      found;
      logic [POSITION_WIDTH-1:0] position;
      logic [COUNT_WIDTH-1:0]    count_after;
   } set_outcome_type;

   logic clock;
   logic reset;

   sks_req_if req_bus ();
   sks_rsp_if rsp_bus ();

   sorted_key_set_core #(
      .DEPTH     (SET_DEPTH),
      .KEY_WIDTH (IN_KEY_WIDTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the sorted set and its predictor
   // ------------------------------------------------------------------
   logic [IN_KEY_WIDTH-1:0] shadow_keys [SET_DEPTH];
   int unsigned             shadow_count = 0;

   set_op_type      pending_ops [$];
   set_outcome_type expected_outcomes [$];

   logic [IN_KEY_WIDTH-1:0] key_pool [POOL_SIZE];

   int unsigned ops_taken   = 0;
   int unsigned phase_len   = 1;
   int unsigned fail_count  = 0;
   int unsigned quiet_count = 0;
   int unsigned next_hold_at = 300;
   int unsigned hold_left   = 0;
   logic        req_fired   = 1'b0;

   // coverage tallies for the summary
   int unsigned n_insert = 0, n_remove = 0, n_lookup = 0, n_spare = 0;
   int unsigned n_full = 0, n_missing = 0, n_dup_hit = 0, peak_count = 0;

   // Apply one operation to the shadow set and return what the block must report.
   // Insert goes after equal keys (upper bound); remove/lookup use the first
   // equal key (lower bound).
   function automatic set_outcome_type predict_set_op(logic [1:0] kind,
                                                      logic [IN_KEY_WIDTH-1:0] key);
      set_outcome_type outc;
      int unsigned  lower;
      int unsigned  upper;
      int unsigned  i;
      bit           present;

      lower = shadow_count;
      upper = shadow_count;
      for (i = 0; i < shadow_count; i++) begin
         if (lower == shadow_count && shadow_keys[i] >= key) lower = i;
         if (upper == shadow_count && shadow_keys[i] > key)  upper = i;
      end
      present = (lower < shadow_count) && (shadow_keys[lower] == key);

      outc.status   = STATUS_OK;
      outc.found    = present;
      outc.position = '0;

      if (kind == KIND_INSERT) begin
         if (shadow_count >= SET_DEPTH) begin
            outc.status = STATUS_FULL;
         end else begin
            for (i = shadow_count; i > upper; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[upper] = key;
            shadow_count++;
            outc.position = upper[POSITION_WIDTH-1:0];
         end
      end else if (kind == KIND_REMOVE) begin
         if (!present) begin
            outc.status = STATUS_NOT_FOUND;
         end else begin
            for (i = lower; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_count--;
            outc.position = lower[POSITION_WIDTH-1:0];
         end
      end else begin
         // lookup and the spare code
         if (present) outc.position = lower[POSITION_WIDTH-1:0];
         else outc.status = STATUS_NOT_FOUND;
      end

      outc.count_after = shadow_count[COUNT_WIDTH-1:0];
      return outc;
   endfunction

   // Idle percentage for each side, stepped by how far the run has got:
   // sender light / receiver heavy, then swapped, then none.
   function automatic int unsigned idle_pct(bit is_sender);
      if (ops_taken < phase_len)          return is_sender ? 17 : 60;
      else if (ops_taken < 2 * phase_len) return is_sender ? 60 : 17;
      else                                return 0;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_op(logic [1:0] kind, logic [IN_KEY_WIDTH-1:0] key, bit wait_idle);
      set_op_type op;
      op.kind      = kind;
      op.key       = key;
      op.wait_idle = wait_idle;
      pending_ops.push_back(op);
   endtask

   // New key pool per epoch: both extremes plus random keys, some of them
   // adjacent values so ordering at +/-1 boundaries gets exercised.
   task automatic refresh_pool();
      int unsigned i;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) begin
         if (i % 3 == 0) key_pool[i] = key_pool[i-1] + 1'b1;
         else            key_pool[i] = $urandom;
      end
   endtask

   // One run of n items with the given mix (percent insert/remove/lookup,
   // remainder spare code). Keys mostly from the pool so hits and duplicates
   // are common; the rest fully random to toggle every key bit.
   task automatic queue_segment(int unsigned ins_pct, int unsigned rem_pct,
                                int unsigned look_pct, int unsigned n, bit wait_first);
      int unsigned             j;
      int unsigned             roll;
      logic [1:0]              kind;
      logic [IN_KEY_WIDTH-1:0] key;
      for (j = 0; j < n; j++) begin
         roll = $urandom_range(99);
         if (roll < ins_pct)                          kind = KIND_INSERT;
         else if (roll < ins_pct + rem_pct)            kind = KIND_REMOVE;
         else if (roll < ins_pct + rem_pct + look_pct) kind = KIND_LOOKUP;
         else                                          kind = KIND_SPARE;
         if ($urandom_range(99) < 75) key = key_pool[$urandom_range(POOL_SIZE-1)];
         else                         key = $urandom;
         push_op(kind, key, wait_first && (j == 0));
      end
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Request driver: changes inputs on the falling edge. A new item goes
   // out only when the line is free or the last one was just taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (pending_ops.size() > 0
             && !(pending_ops[0].wait_idle && expected_outcomes.size() > 0)
             && $urandom_range(99) >= idle_pct(1'b1)) begin
            req_bus.valid <= 1'b1;
            req_bus.kind  <= pending_ops[0].kind;
            req_bus.key   <= pending_ops[0].key;
            void'(pending_ops.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result-side ready. Mostly random; a few times in the run it holds off
   // for a long stretch so the block backs up and stalls req.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (ops_taken >= next_hold_at) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         next_hold_at  <= next_hold_at + 600;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample both handshakes on the rising edge. Results are
   // checked against the oldest expectation; accepted requests run
   // through the predictor.
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      set_outcome_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result item with nothing outstanding: status %0d position %0d",
                      rsp_bus.status, rsp_bus.position);
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("found", 32'(want.found), 32'(rsp_bus.found));
               check_field("position", 32'(want.position), 32'(rsp_bus.position));
               check_field("count_after", 32'(want.count_after),
                           32'(rsp_bus.count_after));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = predict_set_op(req_bus.kind, req_bus.key);
            expected_outcomes.push_back(want);
            ops_taken++;
            case (req_bus.kind)
               KIND_INSERT: n_insert++;
               KIND_REMOVE: n_remove++;
               KIND_LOOKUP: n_lookup++;
               default:     n_spare++;
            endcase
            if (want.status == STATUS_FULL)      n_full++;
            if (want.status == STATUS_NOT_FOUND) n_missing++;
            if (req_bus.kind == KIND_INSERT && want.found) n_dup_hit++;
            if (shadow_count > peak_count) peak_count = shadow_count;
         end
      end
      req_fired <= !reset && req_bus.valid && req_bus.ready;
   end

   // Watchdog: too long with no item moving on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("sorted_key_set_core test failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned first_random;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_LOOKUP;
      req_bus.key   = '0;
      rsp_bus.ready = 1'b0;

      // directed: empty-set misses, extremes, duplicates, spare code
      push_op(KIND_LOOKUP, 32'h0000_0000, 1'b0);   // lookup on empty set
      push_op(KIND_REMOVE, 32'h0000_0005, 1'b0);   // remove on empty set
      push_op(KIND_INSERT, 32'hFFFF_FFFF, 1'b0);
      push_op(KIND_INSERT, 32'h0000_0000, 1'b0);
      push_op(KIND_INSERT, 32'h0000_0000, 1'b0);   // duplicate lands after the first
      push_op(KIND_INSERT, 32'h8000_0000, 1'b0);
      push_op(KIND_INSERT, 32'h7FFF_FFFF, 1'b0);
      push_op(KIND_INSERT, 32'h8000_0000, 1'b0);   // duplicate in the middle
      push_op(KIND_LOOKUP, 32'h0000_0000, 1'b0);   // first of duplicates
      push_op(KIND_LOOKUP, 32'h8000_0000, 1'b0);
      push_op(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);   // top slot
      push_op(KIND_LOOKUP, 32'h8000_0001, 1'b0);   // absent, between keys
      push_op(KIND_SPARE,  32'h7FFF_FFFF, 1'b0);   // spare code acts as lookup
      push_op(KIND_SPARE,  32'h1234_5678, 1'b0);   // spare code, absent key
      push_op(KIND_REMOVE, 32'h8000_0000, 1'b0);   // removes first of the pair
      push_op(KIND_REMOVE, 32'h1234_5678, 1'b0);   // remove of absent key
      push_op(KIND_REMOVE, 32'hFFFF_FFFF, 1'b0);   // remove at the tail
      push_op(KIND_REMOVE, 32'h0000_0000, 1'b0);   // remove at the head
      push_op(KIND_INSERT, 32'h5555_5555, 1'b0);
      push_op(KIND_INSERT, 32'hAAAA_AAAA, 1'b0);
      push_op(KIND_LOOKUP, 32'hAAAA_AAAA, 1'b0);

      // random epochs: fill (drives the set full and into rejects),
      // mixed traffic, then drain. Each epoch waits for the block to go idle.
      first_random = pending_ops.size();
      while (pending_ops.size() < first_random + RANDOM_OPS) begin
         refresh_pool();
         queue_segment(85, 8, 6, $urandom_range(70, 110), 1'b1);
         queue_segment(40, 30, 28, 60, 1'b0);
         queue_segment(10, 75, 13, $urandom_range(80, 120), 1'b0);
      end
      phase_len = pending_ops.size() / 3;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_bus.valid || expected_outcomes.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (expected_outcomes.size() != 0) begin
         $error("%0d results never arrived", expected_outcomes.size());
         fail_count++;
      end

      $display("Covered %0d items: %0d inserts, %0d removes, %0d lookups, %0d spare-code lookups.",
               ops_taken, n_insert, n_remove, n_lookup, n_spare);
      $display("Set peaked at %0d keys; %0d full rejects, %0d misses, %0d duplicate inserts.",
               peak_count, n_full, n_missing, n_dup_hit);

      if (fail_count == 0) begin
         $display("sorted_key_set_core test passed");
      end else begin
         $display("sorted_key_set_core test failed");
      end
      $finish;
   end

endmodule
